[sv/pfr_pkg.sv]
// shared types, constants and helpers of the panel frame receiver
package pfr_pkg;

   // frame and echo test lengths in bytes
   localparam int FRAME_LEN   = 10;
   localparam int ECHO_LEN    = 6;

   // byte store geometry
   localparam int STORE_DEPTH = 16;
   localparam int CNT_W       = 4;

   // line status bits that flag a receive error (parity, framing, overrun)
   localparam logic [7:0] ERR_BITS = 8'h70;

   // command codes carried in tuser of the request channel
   typedef enum logic {
      OP_RX_CHAR  = 1'b0,
      OP_ARM_ECHO = 1'b1
   } opcode_type;

   // inter-character timer actions
   localparam logic [1:0] TIMER_NONE    = 2'd0;
   localparam logic [1:0] TIMER_RESTART = 2'd1;
   localparam logic [1:0] TIMER_STOP    = 2'd2;

   // request payload, last field in the low bits
   typedef struct packed {
      logic [47:0] echo_pattern;
      logic [7:0]  rx_status;
      logic [7:0]  rx_byte;
   } req_type;

   // response payload, last field in the low bits, padded to whole bytes
   typedef struct packed {
      logic [1:0]  pad;
      logic [15:0] switch_word_two;
      logic [15:0] switch_word_one;
      logic [27:0] switch_pressed;
      logic [27:0] switch_image;
      logic [15:0] unit_status;
      logic [1:0]  timer_action;
      logic        echo_match;
      logic        echo_done;
      logic        frame_done;
      logic        line_error;
   } rsp_type;

   // bit reversal of one byte
   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7 - i] = v[i];
      end
      return r;
   endfunction

endpackage

[sv/panel_frame_receiver_core.sv]
// panel frame receiver: uart characters in, frame and echo test results out
//
// Usage: each request beat carries one received character with its line
// status (tuser = 0) or an arm command for the echo test (tuser = 1) with
// six expected bytes. Every request beat yields exactly one response beat.
// A character with a parity, framing or overrun bit reports line_error and
// clears the byte count. Good characters are stored; in normal mode the
// tenth byte completes a panel frame and the response carries the unit
// status, switch image, newly pressed switches and partly bit-reversed switch
// words. In echo test mode the sixth byte ends the test with a match flag.
// The response follows its request in the next cycle. Throughput is
// one beat per cycle, set by the single response register: a new request
// is taken whenever that register is empty or is drained in the same cycle.
// When the response side stalls, the held beat stays stable and req_tready
// drops until it is taken. Reset clears the byte count, the echo test
// state, the armed pattern, the previous switch image and the response
// valid; the stored frame bytes are not cleared.
module panel_frame_receiver_core
   import pfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // rx_byte, rx_status, echo_pattern
   input  logic         req_tuser,   // opcode
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata    // line_error, frame_done, echo_done, echo_match,
                                     // timer_action, unit_status, switch_image,
                                     // switch_pressed, switch_word_one,
                                     // switch_word_two, zero pad
);

   // state registers
   logic [7:0]       frame_ff [STORE_DEPTH];
   logic [CNT_W-1:0] count_ff,   count_in;
   logic             echo_ff,    echo_in;
   logic [47:0]      armed_ff,   armed_in;
   logic [27:0]      last_sw_ff, last_sw_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff,     rsp_in;

   req_type          req;
   logic             accept;
   logic             store_byte;
   logic [CNT_W:0]   count_plus;
   logic [7:0]       view [STORE_DEPTH];
   logic [63:0]      want;
   logic             match;
   logic [27:0]      img;

   assign req        = req_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // byte store as seen after this beat's write
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         view[i] = (count_ff == CNT_W'(i)) ? req.rx_byte : frame_ff[i];
      end
   end

   // echo comparison, pattern bytes past the sixth read as zero
   always_comb begin
      want  = {16'h0000, armed_ff};
      match = 1'b1;
      for (int i = 0; i < ECHO_LEN; i++) begin
         if (want[8*i +: 8] != view[i]) begin
            match = 1'b0;
         end
      end
   end

   assign img = {frame_ff[2], frame_ff[3][3:0], frame_ff[0], frame_ff[1]};
   assign count_plus = {1'b0, count_ff} + (CNT_W+1)'(1);

   // per-beat decision
   always_comb begin
      count_in     = count_ff;
      echo_in      = echo_ff;
      armed_in     = armed_ff;
      last_sw_in   = last_sw_ff;
      rsp_in       = '0;
      store_byte   = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (opcode_type'(req_tuser) == OP_ARM_ECHO) begin
            armed_in = req.echo_pattern;
            echo_in  = 1'b1;
            count_in = '0;
         end else if ((req.rx_status & ERR_BITS) != 8'h00) begin
            rsp_in.line_error = 1'b1;
            count_in          = '0;
         end else begin
            store_byte = 1'b1;
            if (echo_ff) begin
               if (count_plus >= (CNT_W+1)'(ECHO_LEN)) begin
                  rsp_in.echo_done    = 1'b1;
                  rsp_in.echo_match   = match;
                  rsp_in.timer_action = TIMER_STOP;
                  echo_in             = 1'b0;
                  count_in            = '0;
               end else begin
                  rsp_in.timer_action = TIMER_RESTART;
                  count_in            = count_plus[CNT_W-1:0];
               end
            end else if (count_plus >= (CNT_W+1)'(FRAME_LEN)) begin
               // frame complete: only bytes 0 to 5 are decoded
               rsp_in.frame_done      = 1'b1;
               rsp_in.timer_action    = TIMER_STOP;
               rsp_in.unit_status     = {view[4], view[5]};
               rsp_in.switch_image    = img;
               rsp_in.switch_pressed  = img & ~last_sw_ff;
               rsp_in.switch_word_one = {rev8(view[1]), rev8(view[0])};
               rsp_in.switch_word_two = {view[3][0], view[3][1], view[3][2], view[3][3],
                                         view[2], 4'h0};
               last_sw_in             = img;
               count_in               = '0;
            end else begin
               rsp_in.timer_action = TIMER_RESTART;
               count_in            = count_plus[CNT_W-1:0];
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         echo_ff      <= 1'b0;
         armed_ff     <= '0;
         last_sw_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         echo_ff      <= echo_in;
         armed_ff     <= armed_in;
         last_sw_ff   <= last_sw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload and byte store
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
      if (store_byte) begin
         frame_ff[count_ff] <= req.rx_byte;
      end
   end

endmodule

[sv/pfr_checker.sv]
// port-level checker for the panel frame receiver, bound to the receiver core
module pfr_checker
   import pfr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [63:0]  req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_type'(rsp_tdata);

   // a response beat only goes away once taken
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_tvalid) |-> $past(rsp_tready))
      else $error("response beat dropped without handshake");

   // an errored character shows up as line_error on the next cycle
   a_err_next: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_RX_CHAR)
         && ((req_tdata[15:8] & ERR_BITS) != 8'h00)
      |=> rsp_tvalid && rsp.line_error && (rsp.timer_action == TIMER_NONE))
      else $error("receive error not reported");

   // a completed frame or test stops the timer and carries no line error
   a_done_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.frame_done || rsp.echo_done)
      |-> (rsp.timer_action == TIMER_STOP) && !rsp.line_error
          && !(rsp.frame_done && rsp.echo_done))
      else $error("completion without timer stop");

   // echo match, switch image and unit status only appear with their completion flag
   a_field_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.frame_done
      |-> (rsp.switch_image == '0) && (rsp.unit_status == '0)
          && (rsp.echo_match ? rsp.echo_done : 1'b1))
      else $error("result fields set without completion");

endmodule

bind panel_frame_receiver_core pfr_checker u_pfr_checker (.*);

[dv/panel_frame_receiver_core_tb.sv]
// testbench of the panel frame receiver core: random streams checked against a built-in predictor
module panel_frame_receiver_core_tb;
   import pfr_pkg::*;

   // tracks the block state and the results still owed by it
   class panel_scoreboard;
      logic [7:0]  held_bytes [STORE_DEPTH];
      logic [3:0]  byte_count;
      bit          echo_on;
      logic [47:0] armed_pattern;
      logic [27:0] prev_switches;
      rsp_type     awaited_results [$];
      int          mismatches;
      int          checked;
      int          frames;
      int          echo_matches;
      int          echo_misses;
      int          line_errors;

      function new();
         foreach (held_bytes[i]) held_bytes[i] = 8'h00;
         byte_count    = '0;
         echo_on       = 1'b0;
         armed_pattern = '0;
         prev_switches = '0;
      endfunction

      function logic [7:0] mirror8(logic [7:0] v);
         logic [7:0] r;
         for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
         end
         return r;
      endfunction

      // work out the result of one accepted request beat and queue it
      function void note_request(opcode_type op, req_type d);
         rsp_type     r;
         logic [4:0]  next_count;
         logic [7:0]  want;
         logic [7:0]  b0, b1, b2, b3;
         logic [27:0] image;
         bit          same;
         r = '0;
         if (op == OP_ARM_ECHO) begin
            armed_pattern = d.echo_pattern;
            echo_on       = 1'b1;
            byte_count    = '0;
         end else if ((d.rx_status & ERR_BITS) != 8'h00) begin
            r.line_error = 1'b1;
            byte_count   = '0;
         end else begin
            held_bytes[byte_count] = d.rx_byte;
            next_count = {1'b0, byte_count} + 5'd1;
            if (echo_on) begin
               if (next_count >= ECHO_LEN) begin
                  same = 1'b1;
                  for (int i = 0; i < ECHO_LEN && i < 8; i++) begin
                     want = (i < 6) ? armed_pattern[8 * i +: 8] : 8'h00;
                     if (want != held_bytes[i % STORE_DEPTH]) same = 1'b0;
                  end
                  r.echo_done    = 1'b1;
                  r.echo_match   = same;
                  r.timer_action = TIMER_STOP;
                  echo_on        = 1'b0;
                  byte_count     = '0;
               end else begin
                  r.timer_action = TIMER_RESTART;
                  byte_count     = next_count[3:0];
               end
            end else if (next_count >= FRAME_LEN) begin
               b0 = held_bytes[0];
               b1 = held_bytes[1];
               b2 = held_bytes[2];
               b3 = held_bytes[3];
               image = {b2, b3[3:0], b0, b1};
               r.frame_done      = 1'b1;
               r.timer_action    = TIMER_STOP;
               r.unit_status     = {held_bytes[4], held_bytes[5]};
               r.switch_image    = image;
               r.switch_pressed  = image & ~prev_switches;
               r.switch_word_one = {mirror8(b1), mirror8(b0)};
               r.switch_word_two = {b3[0], b3[1], b3[2], b3[3], b2, 4'h0};
               prev_switches     = image;
               byte_count        = '0;
            end else begin
               r.timer_action = TIMER_RESTART;
               byte_count     = next_count[3:0];
            end
         end
         awaited_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: %s expected %h, got %h", checked, name, want, got);
         end
      endfunction

      // compare one accepted response beat with the oldest expectation
      function void check_response(rsp_type got);
         rsp_type e;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response beat with nothing awaited: %h", got);
            return;
         end
         e = awaited_results.pop_front();
         compare_field("line_error", 32'(e.line_error), 32'(got.line_error));
         compare_field("frame_done", 32'(e.frame_done), 32'(got.frame_done));
         compare_field("echo_done", 32'(e.echo_done), 32'(got.echo_done));
         compare_field("echo_match", 32'(e.echo_match), 32'(got.echo_match));
         compare_field("timer_action", 32'(e.timer_action), 32'(got.timer_action));
         compare_field("unit_status", 32'(e.unit_status), 32'(got.unit_status));
         compare_field("switch_image", 32'(e.switch_image), 32'(got.switch_image));
         compare_field("switch_pressed", 32'(e.switch_pressed), 32'(got.switch_pressed));
         compare_field("switch_word_one", 32'(e.switch_word_one),
                       32'(got.switch_word_one));
         compare_field("switch_word_two", 32'(e.switch_word_two),
                       32'(got.switch_word_two));
         compare_field("pad", 32'(e.pad), 32'(got.pad));
         if (e.frame_done) frames++;
         if (e.echo_done && e.echo_match) echo_matches++;
         if (e.echo_done && !e.echo_match) echo_misses++;
         if (e.line_error) line_errors++;
         checked++;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [63:0]  req_tdata;   // rx_byte, rx_status, echo_pattern
   logic         req_tuser;   // opcode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;   // line_error, frame_done, echo_done, echo_match, timer_action,
                              // unit_status, switch_image, switch_pressed, switch_word_one,
                              // switch_word_two, zero pad

   panel_scoreboard sb;
   int              burst_left;
   int              items_sent;
   int              hold_offs;
   bit              hold_off_req;

   panel_frame_receiver_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watch both channels for beats
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(opcode_type'(req_tuser), req_type'(req_tdata));
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_type'(rsp_tdata));
      end
   end

   // receiver: stall pattern steps through readiness levels from always ready to rarely ready, long hold-off on request
   initial begin
      logic [31:0] cyc;
      bit          ready;
      cyc        = '0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (48) @(negedge clock);
            hold_off_req = 1'b0;
            hold_offs++;
         end else begin
            case (cyc[7:6])
               2'd0:    ready = 1'b1;
               2'd1:    ready = ($urandom_range(0, 3) != 0);
               2'd2:    ready = ($urandom_range(0, 1) != 0);
               default: ready = ($urandom_range(0, 7) == 0);
            endcase
            rsp_tready <= ready;
         end
      end
   end

   // offer one request beat, in bursts with random gaps
   task automatic send_beat(input opcode_type op, input req_type d);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      items_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_char(input logic [7:0] b, input logic [7:0] status);
      req_type d;
      d.echo_pattern = {16'($urandom), 32'($urandom)};
      d.rx_status    = status;
      d.rx_byte      = b;
      send_beat(OP_RX_CHAR, d);
   endtask

   task automatic send_arm(input logic [47:0] pattern);
      req_type d;
      d.echo_pattern = pattern;
      d.rx_status    = 8'($urandom);
      d.rx_byte      = 8'($urandom);
      send_beat(OP_ARM_ECHO, d);
   endtask

   // drop valid and wait until every result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] good_status();
      return 8'($urandom) & ~ERR_BITS;
   endfunction

   // stimulus
   initial begin
      int          kind;
      int          next_hold_at;
      int          flip;
      bit          paused;
      logic [47:0] pat;
      logic [7:0]  b;
      logic [7:0]  frame_seed [FRAME_LEN];
      sb           = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = 1'b0;
      req_tdata    = '0;
      burst_left   = 0;
      items_sent   = 0;
      hold_offs    = 0;
      hold_off_req = 1'b0;
      next_hold_at = 150;
      paused       = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: error bits, re-arm, error inside a test, matching echo
      send_char(8'h5a, 8'h10);
      send_arm(48'h0);
      send_arm(48'hffff_ffff_ffff);
      send_char(8'hff, 8'h8f);
      send_char(8'hff, 8'h00);
      send_char(8'h00, 8'h20);
      repeat (ECHO_LEN) send_char(8'hff, 8'h8f);
      // directed: partial frame cut by an error, then a full frame of extremes
      send_char(8'h11, 8'h00);
      send_char(8'h22, 8'h0f);
      send_char(8'h33, 8'h80);
      send_char(8'h44, 8'h40);
      frame_seed = '{8'h01, 8'h80, 8'hff, 8'hf9, 8'hff, 8'h00, 8'h00, 8'hff, 8'h55, 8'haa};
      foreach (frame_seed[i]) send_char(frame_seed[i], 8'h8f);

      // random: mostly whole frames and echo tests, some noise
      while (items_sent < 525) begin
         if (items_sent >= next_hold_at) begin
            hold_off_req = 1'b1;
            next_hold_at += 180;
         end
         if (!paused && items_sent >= 260) begin
            wait_drained();
            paused = 1'b1;
         end
         kind = $urandom_range(0, 19);
         if (kind < 10) begin
            // panel frame, sometimes preceded by a broken start
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(0, FRAME_LEN - 1)) send_char(8'($urandom), good_status());
               send_char(8'($urandom), 8'($urandom) | (8'h10 << $urandom_range(0, 2)));
            end
            repeat (FRAME_LEN) send_char(8'($urandom), good_status());
         end else if (kind < 16) begin
            // echo test, half of them with one wrong byte
            pat = {16'($urandom), 32'($urandom)};
            send_arm(pat);
            flip = ($urandom_range(0, 1) == 0) ? $urandom_range(0, ECHO_LEN - 1) : -1;
            for (int i = 0; i < ECHO_LEN; i++) begin
               b = pat[8 * i +: 8];
               if (i == flip) b = b ^ 8'($urandom_range(1, 255));
               send_char(b, good_status());
            end
         end else begin
            // noise: raw beats with any status, occasional arm
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 5) == 0) send_arm({16'($urandom), 32'($urandom)});
               else send_char(8'($urandom), 8'($urandom));
            end
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      $display("checked %0d results: %0d panel frames, %0d echo matches, %0d echo misses,",
               sb.checked, sb.frames, sb.echo_matches, sb.echo_misses);
      $display("%0d line errors, %0d long receiver hold-offs, %0d mismatches",
               sb.line_errors, hold_offs, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("panel_frame_receiver_core_tb: PASS");
      end else begin
         $display("panel_frame_receiver_core_tb: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("timeout with %0d results still awaited", sb.pending());
      $display("panel_frame_receiver_core_tb: FAIL");
      $finish;
   end

endmodule
